>>> rtl/periodic_timed_event_queue_macros.svh
// Assertion macros for the periodic timed event queue.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef PERIODIC_TIMED_EVENT_QUEUE_MACROS_SVH
`define PERIODIC_TIMED_EVENT_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
`define PEQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PEQ_ASSERT(lbl, prop, msg)
`define PEQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/peq_pkg.sv
// Package for the periodic timed event queue: default sizes, codes and states.
// No dependencies.
`default_nettype none

package peq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;
    localparam int ID_BITS_DEF     = 8;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_FIRED    = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_CLEARED  = 3'd3,
        ST_NOTHING  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_INS_START,
        S_INS_CMP,
        S_TICK_RD,
        S_TICK_CHK,
        S_TICK_END
    } state_t;

endpackage

`default_nettype wire

>>> rtl/periodic_timed_event_queue.sv
// Timed event queue held sorted by due time in a circular buffer in one RAM
// (time, period and id per word, head pointer and count in registers). One item is
// worked at a time. Clear and a full insert go straight to the result beat. An insert
// shifts each queued entry with a later due time up one slot through the single read
// port of the RAM, then writes the new entry. A tick reads and examines head entries,
// puts each fired event whose next due time lies past now back through the insert
// scan, and ends with a final beat; the registered RAM read sets the per-entry cost.
// A result beat held off by the receiver adds its wait.
// Kind 3 is accepted and gives no beat. Result beats wait in an output register.
// Depends on peq_pkg, peq_ram and periodic_timed_event_queue_macros.svh.
`default_nettype none
`include "periodic_timed_event_queue_macros.svh"

module periodic_timed_event_queue
    import peq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           kind,
    input  wire logic [ID_BITS-1:0]   event_id,
    input  wire logic [TIME_BITS-1:0] due_time,
    input  wire logic [TIME_BITS-1:0] repeat_period,
    input  wire logic [TIME_BITS-1:0] now_step,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [2:0]                status,
    output logic [ID_BITS-1:0]        fired_id,
    output logic [TIME_BITS-1:0]      fired_time,
    output logic                      last
);

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int WORD_W = 2 * TIME_BITS + ID_BITS;
    localparam logic [IDX_W:0] DEPTH_V = (IDX_W + 1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 op_tick_reg, op_tick_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]     scan_reg, scan_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [ID_BITS-1:0]   ins_id_reg, ins_id_next;
    logic [TIME_BITS-1:0] ins_time_reg, ins_time_next;
    logic [TIME_BITS-1:0] ins_period_reg, ins_period_next;
    status_t              emit_status_reg, emit_status_next;
    logic [ID_BITS-1:0]   pend_id_reg, pend_id_next;
    logic [TIME_BITS-1:0] pend_time_reg, pend_time_next;
    status_t              out_status_reg, out_status_next;
    logic [ID_BITS-1:0]   out_id_reg, out_id_next;
    logic [TIME_BITS-1:0] out_time_reg, out_time_next;
    logic                 out_last_reg, out_last_next;

    logic                 wr_en, rd_en;
    logic [IDX_W-1:0]     wr_addr, rd_addr;
    logic [WORD_W-1:0]    wr_data, rd_data;
    logic [TIME_BITS-1:0] rd_time, rd_period, next_time;
    logic [ID_BITS-1:0]   rd_id;
    logic [TIME_BITS:0]   time_sum;
    logic [CNT_W-1:0]     count_dec;
    logic [WORD_W-1:0]    ins_word;
    logic                 out_free;
    logic                 in_scan;
    logic                 clear_fire;

    function automatic logic [IDX_W-1:0] wrap_add(
        input logic [IDX_W-1:0] base,
        input logic [IDX_W-1:0] off
    );
        logic [IDX_W:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= DEPTH_V)
        begin
            s = s - DEPTH_V;
        end
        return s[IDX_W-1:0];
    endfunction

    peq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_time   = rd_data[TIME_BITS-1:0];
    assign rd_period = rd_data[2*TIME_BITS-1:TIME_BITS];
    assign rd_id     = rd_data[WORD_W-1:2*TIME_BITS];
    assign time_sum  = {1'b0, rd_time} + {1'b0, rd_period};
    assign next_time = time_sum[TIME_BITS] ? '1 : time_sum[TIME_BITS-1:0];
    assign count_dec = count_reg - 1'b1;
    assign ins_word  = {ins_id_reg, ins_period_reg, ins_time_reg};
    assign out_free  = !out_valid_reg || out_ready;
    assign in_scan    = (state_reg == S_INS_START) || (state_reg == S_INS_CMP);
    assign clear_fire = in_valid && in_ready && (kind == KIND_CLEAR);

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign fired_id   = out_id_reg;
    assign fired_time = out_time_reg;
    assign last       = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            op_tick_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            op_tick_reg    <= op_tick_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg        <= scan_next;
        now_reg         <= now_next;
        ins_id_reg      <= ins_id_next;
        ins_time_reg    <= ins_time_next;
        ins_period_reg  <= ins_period_next;
        emit_status_reg <= emit_status_next;
        pend_id_reg     <= pend_id_next;
        pend_time_reg   <= pend_time_next;
        out_status_reg  <= out_status_next;
        out_id_reg      <= out_id_next;
        out_time_reg    <= out_time_next;
        out_last_reg    <= out_last_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        op_tick_next     = op_tick_reg;
        pend_valid_next  = pend_valid_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        scan_next        = scan_reg;
        now_next         = now_reg;
        ins_id_next      = ins_id_reg;
        ins_time_next    = ins_time_reg;
        ins_period_next  = ins_period_reg;
        emit_status_next = emit_status_reg;
        pend_id_next     = pend_id_reg;
        pend_time_next   = pend_time_reg;
        out_status_next  = out_status_reg;
        out_id_next      = out_id_reg;
        out_time_next    = out_time_reg;
        out_last_next    = out_last_reg;
        wr_en            = 1'b0;
        wr_addr          = head_reg;
        wr_data          = ins_word;
        rd_en            = 1'b0;
        rd_addr          = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (kind)
                        KIND_INSERT:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                emit_status_next = ST_FULL;
                                state_next       = S_EMIT;
                            end
                            else
                            begin
                                ins_id_next     = event_id;
                                ins_time_next   = due_time;
                                ins_period_next = repeat_period;
                                op_tick_next    = 1'b0;
                                scan_next       = count_reg[IDX_W-1:0];
                                state_next      = S_INS_START;
                            end
                        end
                        KIND_TICK:
                        begin
                            now_next        = now_step;
                            op_tick_next    = 1'b1;
                            pend_valid_next = 1'b0;
                            state_next      = S_TICK_RD;
                        end
                        KIND_CLEAR:
                        begin
                            count_next       = '0;
                            head_next        = '0;
                            emit_status_next = ST_CLEARED;
                            state_next       = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = emit_status_reg;
                    out_id_next     = '0;
                    out_time_next   = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_INS_START:
            begin
                if (scan_reg == '0)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = head_reg;
                    wr_data    = ins_word;
                    count_next = count_reg + 1'b1;
                    if (op_tick_reg)
                    begin
                        state_next = S_TICK_RD;
                    end
                    else
                    begin
                        emit_status_next = ST_INSERTED;
                        state_next       = S_EMIT;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = wrap_add(head_reg, scan_reg - 1'b1);
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = wrap_add(head_reg, scan_reg);
                if (rd_time <= ins_time_reg)
                begin
                    wr_data    = ins_word;
                    count_next = count_reg + 1'b1;
                    if (op_tick_reg)
                    begin
                        state_next = S_TICK_RD;
                    end
                    else
                    begin
                        emit_status_next = ST_INSERTED;
                        state_next       = S_EMIT;
                    end
                end
                else
                begin
                    // shift the later entry up one slot
                    wr_data   = rd_data;
                    scan_next = scan_reg - 1'b1;
                    if (scan_reg == IDX_W'(1))
                    begin
                        state_next = S_INS_START;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = wrap_add(head_reg, scan_reg - IDX_W'(2));
                    end
                end
            end

            S_TICK_RD:
            begin
                if (count_reg == '0)
                begin
                    state_next = S_TICK_END;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg;
                    state_next = S_TICK_CHK;
                end
            end

            S_TICK_CHK:
            begin
                if (rd_time <= now_reg)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_FIRED;
                            out_id_next     = pend_id_reg;
                            out_time_next   = pend_time_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = rd_id;
                        pend_time_next  = rd_time;
                        head_next       = wrap_add(head_reg, IDX_W'(1));
                        count_next      = count_dec;
                        if (next_time > now_reg)
                        begin
                            ins_id_next     = rd_id;
                            ins_time_next   = next_time;
                            ins_period_next = rd_period;
                            scan_next       = count_dec[IDX_W-1:0];
                            state_next      = S_INS_START;
                        end
                        else
                        begin
                            state_next = S_TICK_RD;
                        end
                    end
                end
                else
                begin
                    state_next = S_TICK_END;
                end
            end

            S_TICK_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_status_next = ST_FIRED;
                        out_id_next     = pend_id_reg;
                        out_time_next   = pend_time_reg;
                    end
                    else
                    begin
                        out_status_next = ST_NOTHING;
                        out_id_next     = '0;
                        out_time_next   = '0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `PEQ_ASSERT(a_count_bound, count_reg <= DEPTH_C, "entry count beyond queue depth")
    `PEQ_ASSERT(a_ins_room, in_scan |-> (count_reg < DEPTH_C), "insert scan with a full queue")
    `PEQ_ASSERT_NEXT(a_clear_empty, clear_fire, count_reg == '0, "clear left entries queued")

endmodule

`default_nettype wire

>>> rtl/peq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module peq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking bench for periodic_timed_event_queue: directed table, then random traffic.
// Queue model or typed row predicts every beat; both handshakes idle and stall at random.
// Depends on peq_pkg and the RTL of periodic_timed_event_queue.
module tb;
    import peq_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int TB_W = TIME_BITS_DEF;
    localparam int IB_W = ID_BITS_DEF;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RAND_ITEMS = 200;
    localparam int HOLD_AT = 60;
    localparam int PAUSE_AT = 120;
    localparam int QUIET_AT = 170;
    localparam int LONG_HOLD = 150;
    localparam int TAIL_CYCLES = 64;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        status_t          status;
        logic [IB_W-1:0]  id;
        logic [TB_W-1:0]  ftime;
        logic             last;
    } beat_t;

    typedef struct {
        logic [1:0]       op;
        logic [IB_W-1:0]  id;
        logic [TB_W-1:0]  due;
        logic [TB_W-1:0]  period;
        logic [TB_W-1:0]  now;
        bit               typed;
        status_t          want;
    } cmd_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        kind = '0;
    logic [IB_W-1:0]   event_id = '0;
    logic [TB_W-1:0]   due_time = '0;
    logic [TB_W-1:0]   repeat_period = '0;
    logic [TB_W-1:0]   now_step = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [2:0]        status;
    logic [IB_W-1:0]   fired_id;
    logic [TB_W-1:0]   fired_time;
    logic              last;

    logic [TB_W-1:0]   slot_time [DEPTH];
    logic [TB_W-1:0]   slot_period [DEPTH];
    logic [IB_W-1:0]   slot_id [DEPTH];
    int                slot_count;

    beat_t             pending_beats [$];
    cmd_t              directed [$];
    logic [TB_W-1:0]   cur_now;
    bit                hold_now;
    bit                quiet_phase;
    int                fail_cnt;
    int                n_insert, n_tick, n_clear, n_unused;
    int                fired_seen, full_seen, nothing_seen;

    periodic_timed_event_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .event_id      (event_id),
        .due_time      (due_time),
        .repeat_period (repeat_period),
        .now_step      (now_step),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .fired_id      (fired_id),
        .fired_time    (fired_time),
        .last          (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic beat_t mk_beat(input status_t st, input logic [IB_W-1:0] id,
                                      input logic [TB_W-1:0] t, input logic lst);
        beat_t b;
        b.status = st;
        b.id = id;
        b.ftime = t;
        b.last = lst;
        return b;
    endfunction

    function automatic cmd_t mk_cmd(input logic [1:0] op, input logic [IB_W-1:0] id,
                                    input logic [TB_W-1:0] due, input logic [TB_W-1:0] per,
                                    input logic [TB_W-1:0] now, input bit typed,
                                    input status_t want);
        cmd_t c;
        c.op = op;
        c.id = id;
        c.due = due;
        c.period = per;
        c.now = now;
        c.typed = typed;
        c.want = want;
        return c;
    endfunction

    function automatic void queue_beat(input beat_t b);
        pending_beats.insert(pending_beats.size(), b);
    endfunction

    function automatic void add_row(input cmd_t c);
        directed.insert(directed.size(), c);
    endfunction

    // Insert behind every slot due at or before t.
    function automatic void place_event(input logic [IB_W-1:0] id, input logic [TB_W-1:0] t,
                                        input logic [TB_W-1:0] p);
        int pos;
        pos = 0;
        while (pos < slot_count && slot_time[pos] <= t)
            pos++;
        for (int k = slot_count; k > pos; k--)
        begin
            slot_time[k] = slot_time[k-1];
            slot_period[k] = slot_period[k-1];
            slot_id[k] = slot_id[k-1];
        end
        slot_time[pos] = t;
        slot_period[pos] = p;
        slot_id[pos] = id;
        slot_count++;
    endfunction

    function automatic void schedule_item(input cmd_t c);
        beat_t           beats [$];
        logic [IB_W-1:0] fid;
        logic [TB_W-1:0] ft;
        logic [TB_W-1:0] fp;
        logic [TB_W-1:0] nt;
        logic [TB_W:0]   sum;
        if (c.op == KIND_INSERT)
        begin
            if (slot_count >= DEPTH)
                beats.insert(beats.size(), mk_beat(ST_FULL, '0, '0, 1'b1));
            else
            begin
                place_event(c.id, c.due, c.period);
                beats.insert(beats.size(), mk_beat(ST_INSERTED, '0, '0, 1'b1));
            end
        end
        else if (c.op == KIND_CLEAR)
        begin
            slot_count = 0;
            beats.insert(beats.size(), mk_beat(ST_CLEARED, '0, '0, 1'b1));
        end
        else if (c.op == KIND_TICK)
        begin
            while (slot_count > 0 && slot_time[0] <= c.now && beats.size() < DEPTH)
            begin
                fid = slot_id[0];
                ft = slot_time[0];
                fp = slot_period[0];
                for (int k = 1; k < slot_count; k++)
                begin
                    slot_time[k-1] = slot_time[k];
                    slot_period[k-1] = slot_period[k];
                    slot_id[k-1] = slot_id[k];
                end
                slot_count--;
                beats.insert(beats.size(), mk_beat(ST_FIRED, fid, ft, 1'b0));
                sum = {1'b0, ft} + {1'b0, fp};
                nt = sum[TB_W] ? '1 : sum[TB_W-1:0];
                if (nt > c.now)
                    place_event(fid, nt, fp);
            end
            if (beats.size() == 0)
                beats.insert(beats.size(), mk_beat(ST_NOTHING, '0, '0, 1'b1));
            else
                beats[beats.size()-1].last = 1'b1;
        end
        if (c.typed)
            queue_beat(mk_beat(c.want, '0, '0, 1'b1));
        else
            foreach (beats[i])
                queue_beat(beats[i]);
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t            c;
        int              r;
        int              sel;
        c = mk_cmd(KIND_UNUSED, IB_W'($urandom), $urandom, $urandom, $urandom, 1'b0,
                   ST_NOTHING);
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            c.op = KIND_INSERT;
            sel = $urandom_range(0, 9);
            if (sel < 8)
                c.due = cur_now + TB_W'($urandom_range(0, 40));
            else if (sel == 8)
                c.due = $urandom;
            else
                c.due = '1 - TB_W'($urandom_range(0, 3));
            sel = $urandom_range(0, 9);
            if (sel < 3)
                c.period = '0;
            else if (sel < 7)
                c.period = TB_W'($urandom_range(1, 30));
            else if (sel < 9)
                c.period = $urandom;
            else
                c.period = '1 - TB_W'($urandom_range(0, 3));
        end
        else if (r < 85)
        begin
            c.op = KIND_TICK;
            sel = $urandom_range(0, 19);
            if (sel < 17)
            begin
                cur_now = cur_now + TB_W'($urandom_range(0, 20));
                c.now = cur_now;
            end
            else if (sel < 19)
            begin
                c.now = $urandom;
                if (sel == 18)
                    cur_now = c.now;
            end
            else
                c.now = $urandom_range(0, 1) ? '1 : '0;
        end
        else if (r < 95)
            c.op = KIND_CLEAR;
        return c;
    endfunction

    // Offer one beat, then hold it until accepted; returns at the accepting edge.
    task automatic send_item(input cmd_t c, input bit gap);
        int g;
        if (gap)
        begin
            in_valid <= 1'b0;
            g = $urandom_range(1, 7);
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= c.op;
        event_id <= c.id;
        due_time <= c.due;
        repeat_period <= c.period;
        now_step <= c.now;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        case (c.op)
            KIND_INSERT: n_insert++;
            KIND_TICK:   n_tick++;
            KIND_CLEAR:  n_clear++;
            default:     n_unused++;
        endcase
        schedule_item(c);
    endtask

    function automatic bit want_gap();
        return !quiet_phase && $urandom_range(0, 3) == 0;
    endfunction

    task automatic build_directed();
        add_row(mk_cmd(KIND_TICK, '0, '0, '0, '0, 1'b1, ST_NOTHING));
        add_row(mk_cmd(KIND_CLEAR, '1, '1, '1, '1, 1'b1, ST_CLEARED));
        add_row(mk_cmd(KIND_UNUSED, IB_W'($urandom), $urandom, $urandom, $urandom,
                       1'b0, ST_NOTHING));
        add_row(mk_cmd(KIND_INSERT, '1, '1, '1, '0, 1'b1, ST_INSERTED));
        add_row(mk_cmd(KIND_INSERT, '0, '0, '0, '1, 1'b1, ST_INSERTED));
        add_row(mk_cmd(KIND_INSERT, 8'd1, 32'd5, 32'd3, '0, 1'b1, ST_INSERTED));
        add_row(mk_cmd(KIND_INSERT, 8'd2, 32'd5, 32'd3, '0, 1'b1, ST_INSERTED));
        add_row(mk_cmd(KIND_INSERT, 8'd3, 32'hFFFF_FFF0, 32'h20, '0, 1'b1, ST_INSERTED));
        for (int k = 0; k < DEPTH - 5; k++)
            add_row(mk_cmd(KIND_INSERT, IB_W'(16 + k), TB_W'(3 + k), TB_W'(2 * k),
                           $urandom, 1'b1, ST_INSERTED));
        add_row(mk_cmd(KIND_INSERT, 8'hAA, 32'd1, 32'd1, '0, 1'b1, ST_FULL));
        add_row(mk_cmd(KIND_TICK, '0, '0, '0, '0, 1'b0, ST_NOTHING));
        add_row(mk_cmd(KIND_TICK, '0, '0, '0, 32'd5, 1'b0, ST_NOTHING));
        add_row(mk_cmd(KIND_TICK, '0, '0, '0, '1, 1'b0, ST_NOTHING));
        add_row(mk_cmd(KIND_TICK, '0, '0, '0, '1, 1'b1, ST_NOTHING));
        add_row(mk_cmd(KIND_CLEAR, '0, '0, '0, '0, 1'b1, ST_CLEARED));
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (hold_now)
            begin
                hold_now = 1'b0;
                stall_left = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_beats
        beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_beats.size() == 0)
            begin
                $error("result beat with none expected: status=%0d id=%0d time=%0h",
                       status, fired_id, fired_time);
                fail_cnt++;
            end
            else
            begin
                want = pending_beats[0];
                pending_beats.delete(0);
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    fail_cnt++;
                end
                if (fired_id !== want.id)
                begin
                    $error("fired_id: expected %0d, actual %0d", want.id, fired_id);
                    fail_cnt++;
                end
                if (fired_time !== want.ftime)
                begin
                    $error("fired_time: expected %0h, actual %0h", want.ftime, fired_time);
                    fail_cnt++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    fail_cnt++;
                end
                case (want.status)
                    ST_FIRED:   fired_seen++;
                    ST_FULL:    full_seen++;
                    ST_NOTHING: nothing_seen++;
                    default:    ;
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        cmd_t c;
        int   counted;
        slot_count = 0;
        cur_now = '0;
        counted = 0;
        build_directed();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_item(directed[i], want_gap());

        while (counted < RAND_ITEMS)
        begin
            c = random_cmd();
            if (c.op != KIND_UNUSED)
                counted++;
            if (counted == HOLD_AT)
                hold_now = 1'b1;
            if (counted >= QUIET_AT)
                quiet_phase = 1'b1;
            if (counted == PAUSE_AT && c.op != KIND_UNUSED)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_beats.size() != 0)
                    @(posedge clk);
                send_item(c, 1'b0);
            end
            else
                send_item(c, want_gap());
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("items: %0d insert, %0d tick, %0d clear, %0d unused kind",
                 n_insert, n_tick, n_clear, n_unused);
        $display("beats: %0d fired, %0d queue full, %0d nothing due, %0d mismatches",
                 fired_seen, full_seen, nothing_seen, fail_cnt);
        if (fail_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
